@@ rtl/core/value_to_colour_ramp_core_macros.svh @@
// Assertion macros for the value to colour ramp core.
`ifndef VALUE_TO_COLOUR_RAMP_CORE_MACROS_SVH
`define VALUE_TO_COLOUR_RAMP_CORE_MACROS_SVH

// Check cons in the same cycle as ante.
`define VTCR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define VTCR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/vtcr_pkg.sv @@
// Shared types and constants of the value to colour ramp core.
package vtcr_pkg;

  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int CHANNEL_BITS_DEF = 8;
  localparam int CFG_ADDR_BITS    = 4;
  localparam int CFG_DATA_BITS    = 32;
  localparam int QUEUE_DEPTH      = 2;

  typedef enum logic {
    MODE_PLAIN  = 1'b0,
    MODE_SIGNED = 1'b1
  } ramp_mode_t;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_LOW  = 2'd1,
    REG_HIGH = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SRC_OFF  = 2'd0,
    SRC_ZERO = 2'd1,
    SRC_RAMP = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    KIND_DIV  = 2'd0,
    KIND_ZERO = 2'd1,
    KIND_FULL = 2'd2
  } kind_t;

  typedef struct packed {
    src_t  src_r;
    src_t  src_g;
    src_t  src_b;
    logic  off_full;
    logic  flag;
    kind_t kind;
  } ramp_ctl_t;

  localparam int CTL_BITS = $bits(ramp_ctl_t);

endpackage

@@ rtl/core/value_to_colour_ramp_core.sv @@
// Top level of the value to colour ramp core: register port, front end, queue, back end.
// Throughput: one sample per cycle while busy is low; one quotient bit per divider stage.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "value_to_colour_ramp_core_macros.svh"

module value_to_colour_ramp_core
  import vtcr_pkg::*;
#(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [CFG_ADDR_BITS-1:0]      paddr,
  input  logic [CFG_DATA_BITS-1:0]      pwdata,
  output logic [CFG_DATA_BITS-1:0]      prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  output logic [CHANNEL_BITS-1:0]       out_red,
  output logic [CHANNEL_BITS-1:0]       out_green,
  output logic [CHANNEL_BITS-1:0]       out_blue,
  output logic                          out_out_of_range
);

  localparam int MAG_N_BITS = SAMPLE_BITS + 3;
  localparam int MAG_D_BITS = SAMPLE_BITS + 1;
  localparam int Q_WIDTH    = CTL_BITS + MAG_N_BITS + MAG_D_BITS;
  localparam int LATENCY    = CHANNEL_BITS + 7;

  ramp_mode_t                    mode_r;
  ramp_mode_t                    mode_nxt;
  logic signed [SAMPLE_BITS-1:0] low_r;
  logic signed [SAMPLE_BITS-1:0] low_nxt;
  logic signed [SAMPLE_BITS-1:0] high_r;
  logic signed [SAMPLE_BITS-1:0] high_nxt;
  logic                          cfg_wr;
  cfg_idx_t                      cfg_idx;

  logic                          q_push;
  logic                          q_full;
  logic                          q_head_valid;
  ramp_ctl_t                     f_ctl;
  logic [MAG_N_BITS-1:0]         f_mag_n;
  logic [MAG_D_BITS-1:0]         f_mag_d;
  logic [Q_WIDTH-1:0]            q_head;
  ramp_ctl_t                     b_ctl;
  logic [MAG_N_BITS-1:0]         b_mag_n;
  logic [MAG_D_BITS-1:0]         b_mag_d;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = cfg_idx_t'(paddr[3:2]);

  always_comb begin
    mode_nxt = mode_r;
    low_nxt  = low_r;
    high_nxt = high_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE: mode_nxt = ramp_mode_t'(pwdata[0]);
        REG_LOW:  low_nxt  = pwdata[SAMPLE_BITS-1:0];
        REG_HIGH: high_nxt = pwdata[SAMPLE_BITS-1:0];
        default:  mode_nxt = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      low_r  <= '0;
      high_r <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else begin
      mode_r <= mode_nxt;
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE: prdata = CFG_DATA_BITS'(mode_r);
      REG_LOW:  prdata = CFG_DATA_BITS'($unsigned(low_r));
      REG_HIGH: prdata = CFG_DATA_BITS'($unsigned(high_r));
      default:  prdata = '0;
    endcase
  end

  vtcr_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_sample(in_sample),
    .cfg_mode (mode_r),
    .cfg_low  (low_r),
    .cfg_high (high_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_ctl    (f_ctl),
    .q_mag_n  (f_mag_n),
    .q_mag_d  (f_mag_d)
  );

  vtcr_queue #(
    .WIDTH(Q_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_ctl, f_mag_n, f_mag_d}),
    .full      (q_full),
    .pop       (q_head_valid),
    .head_valid(q_head_valid),
    .head_data (q_head)
  );

  assign {b_ctl, b_mag_n, b_mag_d} = q_head;

  vtcr_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (q_head_valid),
    .in_ctl          (b_ctl),
    .in_mag_n        (b_mag_n),
    .in_mag_d        (b_mag_d),
    .out_valid       (out_valid),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_out_of_range(out_out_of_range)
  );

  `VTCR_ASSERT_IMP(a_push_room, q_push, !q_full, "queue push while full")
  `VTCR_ASSERT_NXT(a_drain, q_head_valid && !q_push, !q_head_valid, "queue failed to drain")
  `VTCR_ASSERT_IMP(a_latency, start && !busy, ##LATENCY out_valid, "result missing after transfer")
  `VTCR_ASSERT_IMP(a_blackout, out_valid && out_out_of_range,
    $countones({|out_red, |out_green, |out_blue}) <= 1, "off channels not blanked")

endmodule

@@ rtl/core/vtcr_front.sv @@
// Front end: accept, clamp and classify samples into ramp segments.
module vtcr_front
  import vtcr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  ramp_mode_t                    cfg_mode,
  input  logic signed [SAMPLE_BITS-1:0] cfg_low,
  input  logic signed [SAMPLE_BITS-1:0] cfg_high,
  input  logic                          q_full,
  output logic                          q_push,
  output ramp_ctl_t                     q_ctl,
  output logic [SAMPLE_BITS+2:0]        q_mag_n,
  output logic [SAMPLE_BITS:0]          q_mag_d
);

  localparam int DIFF_BITS  = SAMPLE_BITS + 1;
  localparam int NUM_BITS   = SAMPLE_BITS + 4;
  localparam int MAG_N_BITS = SAMPLE_BITS + 3;

  logic signed [SAMPLE_BITS-1:0] v_lift;
  logic signed [SAMPLE_BITS-1:0] v_clip;
  logic signed [SAMPLE_BITS-1:0] lo_eff;
  logic signed [SAMPLE_BITS-1:0] top_eff;
  logic                          fade;
  logic                          flag;
  logic                          accept;
  logic                          f1_adv;
  logic signed [DIFF_BITS-1:0]   d;
  logic signed [DIFF_BITS-1:0]   dv;

  logic                          f1_v_r;
  logic                          f1_v_nxt;
  logic signed [DIFF_BITS-1:0]   d_r;
  logic signed [DIFF_BITS-1:0]   dv_r;
  logic                          flag_r;
  logic                          fade_r;

  logic signed [NUM_BITS-1:0]    q4;
  logic signed [NUM_BITS-1:0]    dv1;
  logic signed [NUM_BITS-1:0]    dv2;
  logic signed [NUM_BITS-1:0]    dv3;
  logic signed [NUM_BITS-1:0]    dv4;
  logic signed [NUM_BITS-1:0]    num;
  logic signed [NUM_BITS-1:0]    num_abs;
  logic signed [DIFF_BITS-1:0]   dv_abs;
  logic                          base;

  always_comb begin
    if (cfg_mode == MODE_PLAIN) begin
      v_lift = (in_sample < cfg_low) ? cfg_low : in_sample;
      v_clip = (v_lift > cfg_high) ? cfg_high : v_lift;
    end else begin
      v_lift = (in_sample > cfg_high) ? cfg_high : in_sample;
      v_clip = (v_lift < cfg_low) ? cfg_low : v_lift;
    end
    flag = (cfg_mode == MODE_PLAIN) &&
           (cfg_low < 0 || cfg_high < 0 || in_sample < 0 ||
            in_sample > cfg_high || in_sample < cfg_low);
    fade = (cfg_mode == MODE_SIGNED) && (cfg_low < 0) && (v_clip < 0);
    if ((cfg_mode == MODE_SIGNED) && (cfg_low < 0) && !fade) begin
      lo_eff = '0;
    end else begin
      lo_eff = cfg_low;
    end
    top_eff = fade ? '0 : cfg_high;
    d  = DIFF_BITS'(v_clip) - DIFF_BITS'(lo_eff);
    dv = DIFF_BITS'(top_eff) - DIFF_BITS'(lo_eff);
  end

  assign busy     = f1_v_r && q_full;
  assign accept   = start && !busy;
  assign f1_adv   = !f1_v_r || !q_full;
  assign f1_v_nxt = f1_adv ? accept : f1_v_r;
  assign q_push   = f1_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= f1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d_r    <= d;
      dv_r   <= dv;
      flag_r <= flag;
      fade_r <= fade;
    end
  end

  always_comb begin
    q4  = NUM_BITS'(d_r) <<< 2;
    dv1 = NUM_BITS'(dv_r);
    dv2 = dv1 <<< 1;
    dv3 = dv2 + dv1;
    dv4 = dv1 <<< 2;

    q_ctl.off_full = !flag_r;
    q_ctl.flag     = flag_r;

    if (fade_r) begin
      num         = NUM_BITS'(d_r);
      base        = 1'b1;
      q_ctl.src_r = SRC_ZERO;
      q_ctl.src_g = SRC_ZERO;
      q_ctl.src_b = SRC_RAMP;
    end else if (q4 < dv1) begin
      num         = q4;
      base        = 1'b0;
      q_ctl.src_r = SRC_ZERO;
      q_ctl.src_g = SRC_RAMP;
      q_ctl.src_b = SRC_OFF;
    end else if (q4 < dv2) begin
      num         = dv2 - q4;
      base        = 1'b1;
      q_ctl.src_r = SRC_ZERO;
      q_ctl.src_g = SRC_OFF;
      q_ctl.src_b = SRC_RAMP;
    end else if (q4 < dv3) begin
      num         = q4 - dv2;
      base        = 1'b0;
      q_ctl.src_r = SRC_RAMP;
      q_ctl.src_g = SRC_OFF;
      q_ctl.src_b = SRC_ZERO;
    end else begin
      num         = dv4 - q4;
      base        = 1'b1;
      q_ctl.src_r = SRC_OFF;
      q_ctl.src_g = SRC_RAMP;
      q_ctl.src_b = SRC_ZERO;
    end

    if (dv_r == '0) begin
      q_ctl.kind = base ? KIND_FULL : KIND_ZERO;
    end else if ((num != '0) && (num[NUM_BITS-1] != dv_r[DIFF_BITS-1])) begin
      q_ctl.kind = KIND_ZERO;
    end else begin
      q_ctl.kind = KIND_DIV;
    end

    num_abs = num[NUM_BITS-1] ? -num : num;
    dv_abs  = dv_r[DIFF_BITS-1] ? -dv_r : dv_r;
    q_mag_n = num_abs[MAG_N_BITS-1:0];
    q_mag_d = dv_abs;
  end

endmodule

@@ rtl/core/vtcr_queue.sv @@
// Short FIFO between the front end and the arithmetic back end.
module vtcr_queue
  import vtcr_pkg::*;
#(
  parameter int WIDTH = CTL_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;

  assign full       = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_BITS'(push) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/vtcr_back.sv @@
// Back end: scale, pipelined restoring divide, saturate and drive the result.
module vtcr_back
  import vtcr_pkg::*;
#(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    take,
  input  ramp_ctl_t               in_ctl,
  input  logic [SAMPLE_BITS+2:0]  in_mag_n,
  input  logic [SAMPLE_BITS:0]    in_mag_d,
  output logic                    out_valid,
  output logic [CHANNEL_BITS-1:0] out_red,
  output logic [CHANNEL_BITS-1:0] out_green,
  output logic [CHANNEL_BITS-1:0] out_blue,
  output logic                    out_out_of_range
);

  localparam int MAG_N_BITS = SAMPLE_BITS + 3;
  localparam int MAG_D_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS  = MAG_N_BITS + CHANNEL_BITS;
  localparam int DIV_STEPS  = CHANNEL_BITS + 3;
  localparam int REM_BITS   = (PROD_BITS > MAG_D_BITS + DIV_STEPS) ?
                              PROD_BITS : MAG_D_BITS + DIV_STEPS;
  localparam logic [CHANNEL_BITS-1:0] CMAX = '1;

  logic [PROD_BITS-1:0]    prod;

  logic                    st_v_r   [DIV_STEPS+1];
  ramp_ctl_t               st_ctl_r [DIV_STEPS+1];
  logic [REM_BITS-1:0]     st_rem_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0]    st_quo_r [DIV_STEPS+1];
  logic [MAG_D_BITS-1:0]   st_den_r [DIV_STEPS+1];

  logic [REM_BITS-1:0]     trial    [DIV_STEPS];
  logic [REM_BITS-1:0]     rem_nxt  [DIV_STEPS];
  logic [DIV_STEPS-1:0]    quo_nxt  [DIV_STEPS];

  ramp_ctl_t               fin_ctl;
  logic [DIV_STEPS-1:0]    fin_quo;
  logic [CHANNEL_BITS-1:0] ramp_val;
  logic [CHANNEL_BITS-1:0] off_val;

  logic                    out_valid_r;
  logic [CHANNEL_BITS-1:0] red_r;
  logic [CHANNEL_BITS-1:0] green_r;
  logic [CHANNEL_BITS-1:0] blue_r;
  logic                    oor_r;
  logic [CHANNEL_BITS-1:0] red_nxt;
  logic [CHANNEL_BITS-1:0] green_nxt;
  logic [CHANNEL_BITS-1:0] blue_nxt;

  function automatic logic [CHANNEL_BITS-1:0] pick(
    input src_t                    src,
    input logic [CHANNEL_BITS-1:0] ramp,
    input logic [CHANNEL_BITS-1:0] off
  );
    logic [CHANNEL_BITS-1:0] res;
    case (src)
      SRC_RAMP: res = ramp;
      SRC_OFF:  res = off;
      SRC_ZERO: res = '0;
      default:  res = '0;
    endcase
    return res;
  endfunction

  assign prod = PROD_BITS'(in_mag_n) * PROD_BITS'(CMAX);

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k]   = REM_BITS'(st_den_r[k]) << (DIV_STEPS - 1 - k);
      rem_nxt[k] = st_rem_r[k];
      quo_nxt[k] = st_quo_r[k];
      if (st_rem_r[k] >= trial[k]) begin
        rem_nxt[k]                    = st_rem_r[k] - trial[k];
        quo_nxt[k][DIV_STEPS - 1 - k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        st_v_r[k] <= 1'b0;
      end
    end else begin
      st_v_r[0] <= take;
      for (int k = 0; k < DIV_STEPS; k++) begin
        st_v_r[k+1] <= st_v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    st_ctl_r[0] <= in_ctl;
    st_rem_r[0] <= REM_BITS'(prod);
    st_quo_r[0] <= '0;
    st_den_r[0] <= in_mag_d;
    for (int k = 0; k < DIV_STEPS; k++) begin
      st_ctl_r[k+1] <= st_ctl_r[k];
      st_rem_r[k+1] <= rem_nxt[k];
      st_quo_r[k+1] <= quo_nxt[k];
      st_den_r[k+1] <= st_den_r[k];
    end
  end

  always_comb begin
    fin_ctl = st_ctl_r[DIV_STEPS];
    fin_quo = st_quo_r[DIV_STEPS];
    case (fin_ctl.kind)
      KIND_DIV:  ramp_val = (fin_quo > DIV_STEPS'(CMAX)) ? CMAX : fin_quo[CHANNEL_BITS-1:0];
      KIND_FULL: ramp_val = CMAX;
      KIND_ZERO: ramp_val = '0;
      default:   ramp_val = '0;
    endcase
    off_val   = fin_ctl.off_full ? CMAX : '0;
    red_nxt   = pick(fin_ctl.src_r, ramp_val, off_val);
    green_nxt = pick(fin_ctl.src_g, ramp_val, off_val);
    blue_nxt  = pick(fin_ctl.src_b, ramp_val, off_val);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= st_v_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    oor_r   <= fin_ctl.flag;
  end

  assign out_valid        = out_valid_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_out_of_range = oor_r;

endmodule

@@ verif/value_to_colour_ramp_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the value to colour ramp core: directed and random samples.
module value_to_colour_ramp_core_test
  import vtcr_pkg::*;
();

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int CB = CHANNEL_BITS_DEF;
  localparam longint CMAX = (longint'(1) << CB) - 1;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT = 100000;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_ITEMS = 110;
  localparam int MODE_PAD_BITS = CFG_DATA_BITS - 1;
  localparam int BOUND_PAD_BITS = CFG_DATA_BITS - SB;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic          flag;
  } colour_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                 pready;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [SB-1:0] in_sample = '0;
  logic                 out_valid;
  logic [CB-1:0]        out_red;
  logic [CB-1:0]        out_green;
  logic [CB-1:0]        out_blue;
  logic                 out_out_of_range;

  ramp_mode_t           cur_mode = MODE_PLAIN;
  logic signed [SB-1:0] cur_low = '0;
  logic signed [SB-1:0] cur_high = {1'b0, {(SB-1){1'b1}}};

  logic signed [SB-1:0] pending_samples[$];
  colour_t              expected_colours[$];
  int                   idle_pct = 0;
  int                   samples_queued = 0;
  int                   results_checked = 0;
  int                   settings_used = 0;
  int                   err_count = 0;
  int                   cycle_count = 0;

  value_to_colour_ramp_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_out_of_range (out_out_of_range)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [CB-1:0] channel_level(longint base, longint num, longint dv);
    longint t;
    if (dv == 0) begin
      t = base * CMAX;
    end else begin
      t = ((base * dv + num) * CMAX) / dv;
    end
    if (t < 0) t = 0;
    if (t > CMAX) t = CMAX;
    return t[CB-1:0];
  endfunction

  function automatic colour_t ramp_colour(longint d, longint dv, logic [CB-1:0] off);
    colour_t c;
    longint  q;
    q = 4 * d;
    c.red = off;
    c.green = off;
    c.blue = off;
    c.flag = 1'b0;
    if (q < dv) begin
      c.red = '0;
      c.green = channel_level(0, q, dv);
    end else if (q < 2 * dv) begin
      c.red = '0;
      c.blue = channel_level(1, dv - q, dv);
    end else if (q < 3 * dv) begin
      c.red = channel_level(0, q - 2 * dv, dv);
      c.blue = '0;
    end else begin
      c.green = channel_level(1, 3 * dv - q, dv);
      c.blue = '0;
    end
    return c;
  endfunction

  function automatic colour_t predict_colour(logic signed [SB-1:0] s);
    colour_t c;
    longint  v;
    longint  lo;
    longint  hi;
    logic    flag;
    v = s;
    lo = cur_low;
    hi = cur_high;
    flag = 1'b0;
    if (cur_mode == MODE_PLAIN) begin
      if (lo < 0 || hi < 0 || v < 0 || v > hi || v < lo) flag = 1'b1;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      c = ramp_colour(v - lo, hi - lo, flag ? '0 : CMAX[CB-1:0]);
    end else begin
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      if (lo >= 0) begin
        c = ramp_colour(v - lo, hi - lo, CMAX[CB-1:0]);
      end else if (v >= 0) begin
        c = ramp_colour(v, hi, CMAX[CB-1:0]);
      end else begin
        c.red = '0;
        c.green = '0;
        c.blue = channel_level(1, v, -lo);
      end
    end
    c.flag = flag;
    return c;
  endfunction

  function automatic logic signed [SB-1:0] rand_sample(int lo, int hi);
    int a;
    int b;
    int k;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return SB'(a + int'($urandom_range(b - a)));
      6: begin
        case ($urandom_range(3))
          0: return SB'(lo - 1);
          1: return SB'(lo);
          2: return SB'(hi);
          default: return SB'(hi + 1);
        endcase
      end
      7: begin
        k = $urandom_range(3, 1);
        return SB'(lo + ((hi - lo) * k) / 4 + int'($urandom_range(2)) - 1);
      end
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic int rand_bound();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    while (results_checked != samples_queued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_range(ramp_mode_t m, int lo, int hi, int idle);
    logic [CFG_DATA_BITS-1:0] wd_mode;
    logic [CFG_DATA_BITS-1:0] wd_low;
    logic [CFG_DATA_BITS-1:0] wd_high;
    wait_drained();
    wd_mode = {MODE_PAD_BITS'($urandom), m};
    wd_low = {BOUND_PAD_BITS'($urandom), lo[SB-1:0]};
    wd_high = {BOUND_PAD_BITS'($urandom), hi[SB-1:0]};
    cfg_write(REG_MODE, wd_mode);
    cfg_write(REG_LOW, wd_low);
    cfg_write(REG_HIGH, wd_high);
    cur_mode = ramp_mode_t'(wd_mode[0]);
    cur_low = wd_low[SB-1:0];
    cur_high = wd_high[SB-1:0];
    idle_pct = idle;
    settings_used++;
  endtask

  task automatic queue_sample(int v);
    pending_samples.push_back(v[SB-1:0]);
    samples_queued++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_colours.push_back(predict_colour(in_sample));
      if (!start || !busy) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_sample <= pending_samples.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    colour_t e;
    if (rst_n && out_valid) begin
      if (expected_colours.size() == 0) begin
        $error("colour result with no sample waiting: r=%0d g=%0d b=%0d",
               out_red, out_green, out_blue);
        err_count++;
      end else begin
        e = expected_colours.pop_front();
        if (out_red !== e.red) begin
          $error("red: expected %0d, got %0d", e.red, out_red);
          err_count++;
        end
        if (out_green !== e.green) begin
          $error("green: expected %0d, got %0d", e.green, out_green);
          err_count++;
        end
        if (out_blue !== e.blue) begin
          $error("blue: expected %0d, got %0d", e.blue, out_blue);
          err_count++;
        end
        if (out_out_of_range !== e.flag) begin
          $error("out_of_range: expected %0d, got %0d", e.flag, out_out_of_range);
          err_count++;
        end
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int lo;
    int hi;
    int k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset register values
    queue_sample(-32768); queue_sample(-1); queue_sample(0); queue_sample(8191);
    queue_sample(8192); queue_sample(16384); queue_sample(24576); queue_sample(32767);

    set_range(MODE_SIGNED, -32768, 32767, 0);
    queue_sample(-32768); queue_sample(-16384); queue_sample(-1); queue_sample(0);
    queue_sample(32767);

    // zero range width
    set_range(MODE_PLAIN, 100, 100, 0);
    queue_sample(50); queue_sample(100); queue_sample(200);

    // inverted range
    set_range(MODE_PLAIN, 1000, -1000, 0);
    queue_sample(0); queue_sample(500);

    // negative low bound raises the flag in plain mode
    set_range(MODE_PLAIN, -5, 20, 0);
    queue_sample(-3); queue_sample(10);

    // signed mode with nothing above zero
    set_range(MODE_SIGNED, -10, 0, 0);
    queue_sample(-5); queue_sample(0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 8)
        0: begin lo = -32768; hi = 32767; end
        1: begin lo = 0; hi = 32767; end
        2: begin lo = rand_bound(); hi = rand_bound(); end
        3: begin lo = int'($urandom_range(65468)) - 32768; hi = lo + int'($urandom_range(64)); end
        4: begin lo = rand_bound(); hi = lo; end
        5: begin lo = -int'($urandom_range(32768, 1)); hi = int'($urandom_range(32767)); end
        6: begin lo = 32767; hi = -32768; end
        default: begin lo = int'($urandom_range(1000)); hi = lo + int'($urandom_range(3000, 1)); end
      endcase
      case (p % 4)
        0: k = 0;
        1: k = 46;
        2: k = 0;
        default: k = 32;
      endcase
      set_range((p < RANDOM_PHASES / 2) ? MODE_PLAIN : MODE_SIGNED, lo, hi, k);
      for (int i = 0; i < PHASE_ITEMS; i++) queue_sample(rand_sample(lo, hi));
    end

    while (results_checked != samples_queued) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_colours.size() != 0) begin
      $error("%0d colour results never arrived", expected_colours.size());
      err_count++;
    end
    $display("Sent %0d samples through %0d register settings, both ramp modes,",
             samples_queued, settings_used + 1);
    $display("with and without sender gaps; %0d colour results compared.", results_checked);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/vtcr_pkg.sv
rtl/core/vtcr_front.sv
rtl/core/vtcr_queue.sv
rtl/core/vtcr_back.sv
rtl/core/value_to_colour_ramp_core.sv
verif/value_to_colour_ramp_core_test.sv
